[rtl/fts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fts_pkg: shared types and constants for the formula token scanner
// Token kinds, error codes, scanner states, result record, keyword words
// and character class helpers.
// ----------------------------------------------------------------------------
package fts_pkg;

  localparam int NAME_LEN_DEF  = 4;
  localparam int MAX_NAMES_DEF = 64;

  localparam int KW_COUNT = 7;

  typedef enum logic [2:0] {
    KIND_NAME    = 3'd0,
    KIND_KEYWORD = 3'd1,
    KIND_OPEN    = 3'd2,
    KIND_CLOSE   = 3'd3,
    KIND_END     = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CHAR = 2'd1,
    ERR_LONG = 2'd2,
    ERR_FULL = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_PUSH,
    S_DELIM
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] value;
    logic       new_name;
    err_t       error_code;
    logic       last;
  } res_t;

  // keywords packed with the first character in the low byte
  localparam logic [KW_COUNT-1:0][63:0] KW_WORDS = {
    64'h0000_0000_0054_4F4E, // NOT
    64'h0000_0000_0000_004C, // L
    64'h0000_0000_0000_004D, // M
    64'h0000_0000_0044_4E41, // AND
    64'h0000_0000_0000_524F, // OR
    64'h0000_0000_4E45_4854, // THEN
    64'h0000_0000_0000_5145  // EQ
  };

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
  endfunction

endpackage
`default_nettype wire

[rtl/formula_token_scanner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// formula_token_scanner: character stream to tokens with a name table
// Splits characters into names, keywords, parens and end tokens; names are
// looked up in a table held in a synchronous memory and appended when new.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------
//  in      | character, end_of_input, first            | in_valid/in_ready
//  out     | kind, value, new_name, error_code, last   | out_valid/out_ready
//
//  An item passes through S_DECODE, and through S_PUSH when it gives a token.
//  Finishing a name that is not a keyword walks the name table one entry per
//  cycle through the memory read port. A delimiter that also gives a token is
//  pushed after the name from S_DELIM. Results go through a two-entry output
//  queue; the push stalls while it is full.
//  Reset needs no clearing pass; an item marked first empties the table.
// ----------------------------------------------------------------------------
module formula_token_scanner #(
  parameter int NAME_LEN  = fts_pkg::NAME_LEN_DEF,
  parameter int MAX_NAMES = fts_pkg::MAX_NAMES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] character,
  input  wire logic       end_of_input,
  input  wire logic       first,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      kind,
  output logic [5:0]      value,
  output logic            new_name,
  output logic [1:0]      error_code,
  output logic            last
);

  localparam int BW = 8 * NAME_LEN;
  localparam int LW = $clog2(NAME_LEN + 1);
  localparam int IW = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
  localparam int CW = $clog2(MAX_NAMES + 1);

  fts_pkg::state_t state, state_next;
  logic [7:0]    ch, ch_next;
  logic          eoi, eoi_next;
  logic          in_name, in_name_next;
  logic [BW-1:0] buf_q, buf_next;
  logic [LW-1:0] len, len_next;
  logic [CW-1:0] count, count_next;
  logic          err_hold, err_hold_next;
  logic [CW-1:0] idx, idx_next;
  logic          cmp_valid, cmp_valid_next;
  logic [IW-1:0] cmp_idx, cmp_idx_next;
  fts_pkg::res_t res, res_next;

  logic [BW-1:0] name_mem [MAX_NAMES];
  logic [BW-1:0] rd_data;
  logic          mem_re, mem_we;

  fts_pkg::res_t q0, q1;
  logic [1:0]    ocnt;
  logic          push, pop;

  logic          delim, delim_tok, alnum, kw_hit, tbl_full, do_between;
  logic [2:0]    kw_idx;

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = 0; i < fts_pkg::KW_COUNT; i++) begin
      if (!kw_hit && fts_pkg::KW_WORDS[i] == 64'(buf_q)) begin
        kw_hit = 1'b1;
        kw_idx = 3'(i);
      end
    end
  end

  assign delim_tok = eoi || ch == fts_pkg::CH_OPEN || ch == fts_pkg::CH_CLOSE;
  assign delim     = delim_tok || fts_pkg::is_space(ch);
  assign alnum     = fts_pkg::is_letter(ch) || fts_pkg::is_digit(ch);
  assign tbl_full  = (count == CW'(MAX_NAMES));
  assign in_ready  = (state == fts_pkg::S_IDLE);
  assign pop       = out_valid && out_ready;

  always_comb begin
    state_next     = state;
    ch_next        = ch;
    eoi_next       = eoi;
    in_name_next   = in_name;
    buf_next       = buf_q;
    len_next       = len;
    count_next     = count;
    err_hold_next  = err_hold;
    idx_next       = idx;
    cmp_valid_next = 1'b0;
    cmp_idx_next   = cmp_idx;
    res_next       = res;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    push           = 1'b0;
    do_between     = 1'b0;

    unique case (state)
      fts_pkg::S_IDLE: begin
        if (in_valid) begin
          ch_next    = character;
          eoi_next   = end_of_input;
          state_next = fts_pkg::S_DECODE;
          if (first) begin
            count_next    = '0;
            err_hold_next = 1'b0;
            in_name_next  = 1'b0;
            buf_next      = '0;
            len_next      = '0;
          end
        end
      end
      fts_pkg::S_DECODE: begin
        if (err_hold) begin
          state_next = fts_pkg::S_IDLE;
        end else if (!in_name) begin
          do_between = 1'b1;
        end else if (delim) begin
          in_name_next = 1'b0;
          if (kw_hit) begin
            res_next   = '{fts_pkg::KIND_KEYWORD, 6'(kw_idx), 1'b0,
                           fts_pkg::ERR_NONE, !delim_tok};
            state_next = fts_pkg::S_PUSH;
          end else begin
            idx_next   = '0;
            state_next = fts_pkg::S_SEARCH;
          end
        end else if (alnum) begin
          if (len == LW'(NAME_LEN)) begin
            res_next      = '{fts_pkg::KIND_ERROR, 6'd0, 1'b0, fts_pkg::ERR_LONG, 1'b1};
            err_hold_next = 1'b1;
            state_next    = fts_pkg::S_PUSH;
          end else begin
            for (int i = 0; i < NAME_LEN; i++) begin
              if (len == LW'(i)) buf_next[8*i +: 8] = ch;
            end
            len_next   = len + LW'(1);
            state_next = fts_pkg::S_IDLE;
          end
        end else begin
          res_next      = '{fts_pkg::KIND_ERROR, 6'd0, 1'b0, fts_pkg::ERR_CHAR, 1'b1};
          err_hold_next = 1'b1;
          state_next    = fts_pkg::S_PUSH;
        end
      end
      fts_pkg::S_SEARCH: begin
        if (cmp_valid && rd_data == buf_q) begin
          res_next   = '{fts_pkg::KIND_NAME, 6'(cmp_idx), 1'b0,
                         fts_pkg::ERR_NONE, !delim_tok};
          state_next = fts_pkg::S_PUSH;
        end else if (idx < count) begin
          mem_re         = 1'b1;
          cmp_valid_next = 1'b1;
          cmp_idx_next   = idx[IW-1:0];
          idx_next       = idx + CW'(1);
        end else if (tbl_full) begin
          res_next      = '{fts_pkg::KIND_ERROR, 6'd0, 1'b0, fts_pkg::ERR_FULL, 1'b1};
          err_hold_next = 1'b1;
          state_next    = fts_pkg::S_PUSH;
        end else begin
          mem_we     = 1'b1;
          res_next   = '{fts_pkg::KIND_NAME, 6'(count), 1'b1,
                         fts_pkg::ERR_NONE, !delim_tok};
          count_next = count + CW'(1);
          state_next = fts_pkg::S_PUSH;
        end
      end
      fts_pkg::S_PUSH: begin
        if (ocnt != 2'd2) begin
          push       = 1'b1;
          state_next = res.last ? fts_pkg::S_IDLE : fts_pkg::S_DELIM;
        end
      end
      fts_pkg::S_DELIM: begin
        do_between = 1'b1;
      end
      default: begin
        state_next = fts_pkg::S_IDLE;
      end
    endcase

    if (do_between) begin
      priority if (eoi) begin
        res_next   = '{fts_pkg::KIND_END, 6'd0, 1'b0, fts_pkg::ERR_NONE, 1'b1};
        state_next = fts_pkg::S_PUSH;
      end else if (fts_pkg::is_space(ch)) begin
        state_next = fts_pkg::S_IDLE;
      end else if (ch == fts_pkg::CH_OPEN) begin
        res_next   = '{fts_pkg::KIND_OPEN, 6'd0, 1'b0, fts_pkg::ERR_NONE, 1'b1};
        state_next = fts_pkg::S_PUSH;
      end else if (ch == fts_pkg::CH_CLOSE) begin
        res_next   = '{fts_pkg::KIND_CLOSE, 6'd0, 1'b0, fts_pkg::ERR_NONE, 1'b1};
        state_next = fts_pkg::S_PUSH;
      end else if (fts_pkg::is_letter(ch)) begin
        in_name_next = 1'b1;
        buf_next     = BW'(ch);
        len_next     = LW'(1);
        state_next   = fts_pkg::S_IDLE;
      end else begin
        res_next      = '{fts_pkg::KIND_ERROR, 6'd0, 1'b0, fts_pkg::ERR_CHAR, 1'b1};
        err_hold_next = 1'b1;
        state_next    = fts_pkg::S_PUSH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fts_pkg::S_IDLE;
      in_name   <= 1'b0;
      buf_q     <= '0;
      len       <= '0;
      count     <= '0;
      err_hold  <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_name   <= in_name_next;
      buf_q     <= buf_next;
      len       <= len_next;
      count     <= count_next;
      err_hold  <= err_hold_next;
      cmp_valid <= cmp_valid_next;
    end
    ch      <= ch_next;
    eoi     <= eoi_next;
    idx     <= idx_next;
    cmp_idx <= cmp_idx_next;
    res     <= res_next;
  end

  // name table
  always_ff @(posedge clk) begin
    if (mem_we) name_mem[count[IW-1:0]] <= buf_q;
    if (mem_re) rd_data <= name_mem[idx[IW-1:0]];
  end

  // output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else begin
      ocnt <= ocnt + 2'(push) - 2'(pop);
    end
    if (push && pop) begin
      if (ocnt == 2'd2) begin
        q0 <= q1;
        q1 <= res;
      end else begin
        q0 <= res;
      end
    end else if (pop) begin
      q0 <= q1;
    end else if (push) begin
      if (ocnt == 2'd0) q0 <= res;
      else q1 <= res;
    end
  end

  assign out_valid  = (ocnt != 2'd0);
  assign kind       = q0.kind;
  assign value      = q0.value;
  assign new_name   = q0.new_name;
  assign error_code = q0.error_code;
  assign last       = q0.last;

endmodule
`default_nettype wire

[tb/sv/tb_formula_token_scanner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_formula_token_scanner: self-checking bench for the formula token scanner
// Drives character requests with random bursts and gaps and stalls the token
// side on changing patterns. Every accepted request runs through one shared
// tracker that keeps the name table and the error hold. Each accepted
// token is compared with the oldest token still due. Directed text covers
// all keywords, parens, repeated end, case and every error; random formulas,
// noise and two table-full passes follow.
// ----------------------------------------------------------------------------
import fts_pkg::*;

typedef enum int {
  KW_EQ, KW_THEN, KW_OR, KW_AND, KW_M, KW_L, KW_NOT
} kw_t;

function automatic string keyword_text(int k);
  case (kw_t'(k))
    KW_EQ:   return "EQ";
    KW_THEN: return "THEN";
    KW_OR:   return "OR";
    KW_AND:  return "AND";
    KW_M:    return "M";
    KW_L:    return "L";
    default: return "NOT";
  endcase
endfunction

class token_ledger;
  res_t        tokens_due[$];
  int          mismatches;
  logic        in_name;
  logic        halted;
  logic [63:0] word;
  int          word_len;
  logic [63:0] names[MAX_NAMES_DEF];
  int          name_total;

  function void clear();
    in_name    = 1'b0;
    halted     = 1'b0;
    word       = '0;
    word_len   = 0;
    name_total = 0;
  endfunction

  function bit letter(logic [7:0] ch);
    return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
  endfunction

  function bit spacing(logic [7:0] ch);
    return ch == CH_SPACE || ch == CH_TAB || ch == CH_LF;
  endfunction

  function logic [63:0] pack_text(string s);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < s.len(); i++) w |= 64'(s[i]) << (8 * i);
    return w;
  endfunction

  function void emit(kind_t k, int v, logic fresh, err_t e);
    res_t r;
    r.kind       = k;
    r.value      = 6'(v);
    r.new_name   = fresh;
    r.error_code = e;
    r.last       = 1'b0;
    tokens_due.push_back(r);
  endfunction

  function void abort(err_t e);
    emit(KIND_ERROR, 0, 1'b0, e);
    halted = 1'b1;
  endfunction

  // keyword, then table lookup, then append
  function bit close_name();
    in_name = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (pack_text(keyword_text(k)) == word) begin
        emit(KIND_KEYWORD, k, 1'b0, ERR_NONE);
        return 1'b1;
      end
    end
    for (int i = 0; i < name_total; i++) begin
      if (names[i] == word) begin
        emit(KIND_NAME, i, 1'b0, ERR_NONE);
        return 1'b1;
      end
    end
    if (name_total >= MAX_NAMES_DEF) begin
      abort(ERR_FULL);
      return 1'b0;
    end
    names[name_total] = word;
    emit(KIND_NAME, name_total, 1'b1, ERR_NONE);
    name_total++;
    return 1'b1;
  endfunction

  // returns 0 when the request is ignored under an error hold
  function bit take_char(logic [7:0] ch, logic eoi, logic lead);
    bit delim;
    bit done;
    int queued;
    if (lead) clear();
    if (halted) return 1'b0;
    queued = tokens_due.size();
    delim  = eoi || spacing(ch) || ch == CH_OPEN || ch == CH_CLOSE;
    done   = 1'b0;
    if (in_name) begin
      if (delim) begin
        done = !close_name();
      end else begin
        done = 1'b1;
        if (!letter(ch) && !(ch >= 8'h30 && ch <= 8'h39)) abort(ERR_CHAR);
        else if (word_len >= NAME_LEN_DEF) abort(ERR_LONG);
        else begin
          word |= 64'(ch) << (8 * word_len);
          word_len++;
        end
      end
    end
    if (!done) begin
      if (eoi) emit(KIND_END, 0, 1'b0, ERR_NONE);
      else if (ch == CH_OPEN) emit(KIND_OPEN, 0, 1'b0, ERR_NONE);
      else if (ch == CH_CLOSE) emit(KIND_CLOSE, 0, 1'b0, ERR_NONE);
      else if (letter(ch)) begin
        in_name  = 1'b1;
        word     = 64'(ch);
        word_len = 1;
      end else if (!spacing(ch)) abort(ERR_CHAR);
    end
    if (tokens_due.size() > queued) tokens_due[$].last = 1'b1;
    return 1'b1;
  endfunction

  function void match_token(res_t got);
    res_t want;
    if (tokens_due.size() == 0) begin
      $display("%0t: unexpected token kind %0d value %0d new %0b err %0d last %0b",
               $time, got.kind, got.value, got.new_name, got.error_code, got.last);
      mismatches++;
      return;
    end
    want = tokens_due.pop_front();
    if (got.kind !== want.kind || got.value !== want.value ||
        got.new_name !== want.new_name || got.error_code !== want.error_code ||
        got.last !== want.last) begin
      $display("%0t: token mismatch: expected kind %0d value %0d new %0b err %0d last %0b",
               $time, want.kind, want.value, want.new_name, want.error_code, want.last);
      $display("%0t:                 actual   kind %0d value %0d new %0b err %0d last %0b",
               $time, got.kind, got.value, got.new_name, got.error_code, got.last);
      mismatches++;
    end
  endfunction
endclass

module tb_formula_token_scanner;

  localparam int ITEMS = 1900;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [7:0] character    = 8'h00;
  logic       end_of_input = 1'b0;
  logic       first        = 1'b0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [2:0] kind;
  logic [5:0] value;
  logic       new_name;
  logic [1:0] error_code;
  logic       last;

  token_ledger ledger;
  int          live_items = 0;
  int          burst_left = 0;
  bit          lead_first = 1'b0;
  int          stall_cycle = 0;
  int          stall_mode = 0;
  int          stall_left = 0;
  string       name_pool[12] = '{"x", "y1", "ab", "Q9", "eq", "Eq", "EQa", "THE",
                                 "zz", "Mx", "n0ta", "LL"};

  formula_token_scanner DUT (
    .clk, .rst, .in_valid, .in_ready, .character, .end_of_input, .first,
    .out_valid, .out_ready, .kind, .value, .new_name, .error_code, .last
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    if (stall_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
    stall_cycle++;
    case (stall_mode)
      0: out_ready = 1'b1;
      1: out_ready = ($urandom_range(0, 3) != 0);
      2: out_ready = (stall_cycle % 5 == 0);
      default: begin
        if (stall_left == 0) begin
          out_ready  = ~out_ready;
          stall_left = $urandom_range(1, 12);
        end else stall_left--;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      ledger.match_token('{kind_t'(kind), value, new_name, err_t'(error_code), last});
  end

  task automatic send(logic [7:0] ch, logic eoi, logic lead);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     = 1'b1;
    character    = ch;
    end_of_input = eoi;
    first        = lead;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    live_items += ledger.take_char(ch, eoi, lead);
  endtask

  task automatic put(logic [7:0] ch, logic eoi);
    send(ch, eoi, lead_first);
    lead_first = 1'b0;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
  endtask

  task automatic put_end();
    put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic put_random_name(int len);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 2) == 0) ch = 8'($urandom_range(8'h30, 8'h39));
      else if ($urandom_range(0, 1) != 0) ch = 8'($urandom_range(8'h41, 8'h5A));
      else ch = 8'($urandom_range(8'h61, 8'h7A));
      put(ch, 1'b0);
    end
  endtask

  task automatic put_gap();
    case ($urandom_range(0, 5))
      0: put(CH_SPACE, 1'b0);
      1: put(CH_TAB, 1'b0);
      2: put(CH_LF, 1'b0);
      3: put(CH_OPEN, 1'b0);
      4: put(CH_CLOSE, 1'b0);
      default: begin
        put(CH_SPACE, 1'b0);
        put(CH_SPACE, 1'b0);
      end
    endcase
  endtask

  task automatic put_noise();
    case ($urandom_range(0, 4))
      0: put(8'($urandom_range(0, 255)), 1'b0);
      1: put(8'h0D, 1'b0);
      2: put_random_name($urandom_range(NAME_LEN_DEF + 1, NAME_LEN_DEF + 3));
      3: put(8'($urandom_range(8'h30, 8'h39)), 1'b0);
      default: put(8'($urandom_range(128, 255)), 1'b0);
    endcase
  endtask

  task automatic rand_formula();
    int n_tok;
    int noise_at;
    lead_first = ($urandom_range(0, 9) != 0);
    n_tok      = $urandom_range(0, 10);
    noise_at   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_tok) : -1;
    for (int t = 0; t < n_tok; t++) begin
      if (t == noise_at) put_noise();
      case ($urandom_range(0, 7))
        0, 1, 2: put_text(name_pool[$urandom_range(0, 11)]);
        3:       put_random_name($urandom_range(1, NAME_LEN_DEF));
        4, 5:    put_text(keyword_text($urandom_range(0, KW_COUNT - 1)));
        6:       put(CH_OPEN, 1'b0);
        default: put(CH_CLOSE, 1'b0);
      endcase
      if (t < n_tok - 1 || $urandom_range(0, 1) != 0) put_gap();
    end
    if (noise_at == n_tok) put_noise();
    if ($urandom_range(0, 7) != 0) begin
      put_end();
      if ($urandom_range(0, 5) == 0) put_end();
    end
  endtask

  // fill every table slot, hit the last slot, then overflow
  task automatic fill_table(bit by_end);
    lead_first = 1'b1;
    for (int i = 0; i < MAX_NAMES_DEF; i++) begin
      put(8'h6B, 1'b0);
      put(8'(8'h61 + i / 26), 1'b0);
      put(8'(8'h61 + i % 26), 1'b0);
      put(CH_SPACE, 1'b0);
    end
    put_text("kcl ");
    put_text("zzz");
    if (by_end) put_end();
    else put(CH_OPEN, 1'b0);
    put(8'h41, 1'b0);
    put(CH_CLOSE, 1'b0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.tokens_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    ledger = new;
    ledger.clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    lead_first = 1'b1;
    put_text("EQ THEN(OR)AND\tM\nL NOT");
    put_end();
    put_end();
    lead_first = 1'b1;
    put_text("eq Eq eq(");
    put_end();
    lead_first = 1'b1;
    put_text("abcde");
    put(8'h41, 1'b0);
    lead_first = 1'b1;
    put(8'hFF, 1'b0);
    lead_first = 1'b1;
    put(8'h00, 1'b0);

    drain();
    fill_table(1'b0);
    while (live_items < ITEMS / 2) rand_formula();
    drain();
    fill_table(1'b1);
    while (live_items < ITEMS) rand_formula();

    drain();
    repeat (MAX_NAMES_DEF + 20) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.tokens_due.size() == 0)
      $display("** formula_token_scanner: PASSED **");
    else
      $display("** formula_token_scanner: FAILED **");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("** formula_token_scanner: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
